/* rtl/sasg_pkg.sv */
// ----------------------------------------------------------------------------
// sasg_pkg
// Shared types and constants of the stepper axis step generator.
// ----------------------------------------------------------------------------
package sasg_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int MOVE_DEPTH   = 16;
  localparam int TIMING_DEPTH = 16;
  localparam int MQ_AW        = $clog2(MOVE_DEPTH);
  localparam int TQ_AW        = $clog2(TIMING_DEPTH);
  localparam int MQ_CW        = $clog2(MOVE_DEPTH + 1);
  localparam int TQ_CW        = $clog2(TIMING_DEPTH + 1);
  localparam int ENTRY_W      = 48;
  localparam int PADDR_W      = 4;
  localparam int RCP_ITER     = 17;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_MOVE   = 2'd1;
  localparam logic [1:0] CMD_TIMING = 2'd2;

  localparam logic [PADDR_W-1:0] REG_FREQ  = 4'h0;
  localparam logic [PADDR_W-1:0] REG_SPEED = 4'h4;
  localparam logic [PADDR_W-1:0] REG_ACCEL = 4'h8;

  // Datapath operations, at most one per controller step.
  localparam logic [3:0] OP_NONE      = 4'd0;
  localparam logic [3:0] OP_PUSH      = 4'd1;
  localparam logic [3:0] OP_POP_T     = 4'd2;
  localparam logic [3:0] OP_POP_M     = 4'd3;
  localparam logic [3:0] OP_MUL_A     = 4'd4;
  localparam logic [3:0] OP_MUL_Q     = 4'd5;
  localparam logic [3:0] OP_MUL_L     = 4'd6;
  localparam logic [3:0] OP_PROG      = 4'd7;
  localparam logic [3:0] OP_MUL_S     = 4'd8;
  localparam logic [3:0] OP_STEP      = 4'd9;
  localparam logic [3:0] OP_FINISH    = 4'd10;
  localparam logic [3:0] OP_MUL_L2    = 4'd11;
  localparam logic [3:0] OP_DIV_START = 4'd12;

  typedef struct packed {
    logic [3:0] op;
    logic       clear_flags;
  } sasg_cmd_t;

  typedef struct packed {
    logic timing_due;
    logic move_due;
    logic div_done;
  } sasg_status_t;

  typedef struct packed {
    logic        [1:0]  command;
    logic signed [23:0] signed_amount;
    logic        [23:0] span;
  } sasg_in_t;

  typedef struct packed {
    logic               stepped;
    logic               direction;
    logic signed [31:0] motor_position;
    logic        [31:0] progress;
    logic               all_done;
    logic               speed_violation;
    logic               accel_violation;
    logic        [31:0] tick_time;
    logic               push_dropped;
  } sasg_out_t;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (32'd0 - v) : v;
  endfunction

endpackage

/* rtl/sasg_if.sv */
// ----------------------------------------------------------------------------
// sasg_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface sasg_in_if;
  import sasg_pkg::*;
  logic     valid;
  logic     ready;
  sasg_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sasg_out_if;
  import sasg_pkg::*;
  logic      valid;
  logic      ready;
  sasg_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/stepper_axis_step_generator.sv */
// ----------------------------------------------------------------------------
// stepper_axis_step_generator
// One stepper axis: queues, quadratic progress profile and step generation.
// One item at a time: a new item is accepted only in the idle state and
// while no result beat is stalled at the output. A tick waits for the
// bit-serial reciprocal of the step interval; a push goes straight to its result beat.
// Reset: synchronous; queues empty, counters zero, registers to defaults.
// ----------------------------------------------------------------------------
module stepper_axis_step_generator (
  input  logic                         clk,
  input  logic                         rst,
  sasg_in_if.sink                      in_ch,
  sasg_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sasg_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import sasg_pkg::*;

  logic [7:0]   freq_multiplier;
  logic [16:0]  max_speed_q16;
  logic [17:0]  max_accel_q16;
  sasg_cmd_t    cmd;
  sasg_status_t status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      freq_multiplier <= 8'd1;
      max_speed_q16   <= 17'd65536;
      max_accel_q16   <= 18'd131072;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        REG_FREQ:  freq_multiplier <= pwdata[7:0];
        REG_SPEED: max_speed_q16   <= pwdata[16:0];
        REG_ACCEL: max_accel_q16   <= pwdata[17:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      REG_FREQ:  prdata = {24'd0, freq_multiplier};
      REG_SPEED: prdata = {15'd0, max_speed_q16};
      REG_ACCEL: prdata = {14'd0, max_accel_q16};
      default:   prdata = 32'd0;
    endcase
  end

  sasg_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_command(in_ch.data.command), .out_busy(out_ch.valid && !out_ch.ready),
    .status(status), .cmd(cmd)
  );

  sasg_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .in_data(in_ch.data),
    .freq_multiplier(freq_multiplier), .max_speed_q16(max_speed_q16),
    .max_accel_q16(max_accel_q16), .out_valid(out_ch.valid),
    .out_ready(out_ch.ready), .out_data(out_ch.data)
  );
endmodule

/* rtl/sasg_ram.sv */
// ----------------------------------------------------------------------------
// sasg_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module sasg_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/sasg_ctrl.sv */
// ----------------------------------------------------------------------------
// sasg_ctrl
// Sequencer: steps the datapath through one item.
// ----------------------------------------------------------------------------
module sasg_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_command,
  input  logic                  out_busy,
  input  sasg_pkg::sasg_status_t status,
  output sasg_pkg::sasg_cmd_t    cmd
);
  import sasg_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_POPT   = 4'd1;
  localparam logic [3:0] S_POPM   = 4'd2;
  localparam logic [3:0] S_MA0    = 4'd3;
  localparam logic [3:0] S_MQ     = 4'd4;
  localparam logic [3:0] S_ML     = 4'd5;
  localparam logic [3:0] S_PROG   = 4'd6;
  localparam logic [3:0] S_MS     = 4'd7;
  localparam logic [3:0] S_STEP   = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;
  localparam logic [3:0] S_ML2    = 4'd10;
  localparam logic [3:0] S_DIVW   = 4'd11;

  logic [3:0] state, state_next;

  assign in_ready = (state == S_IDLE) && !out_busy;

  always_comb begin
    state_next      = state;
    cmd.op          = OP_NONE;
    cmd.clear_flags = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.clear_flags = 1'b1;
          if (in_command == CMD_TICK) begin
            cmd.op     = OP_DIV_START;
            state_next = S_POPT;
          end else begin
            cmd.op     = OP_PUSH;
            state_next = S_FIN;
          end
        end
      end
      S_POPT: begin
        if (status.timing_due) begin
          cmd.op = OP_POP_T;
        end
        state_next = S_POPM;
      end
      S_POPM: begin
        if (status.move_due) begin
          cmd.op = OP_POP_M;
        end
        state_next = S_MA0;
      end
      S_MA0: begin
        cmd.op     = OP_MUL_A;
        state_next = S_MQ;
      end
      S_MQ: begin
        cmd.op     = OP_MUL_Q;
        state_next = S_ML;
      end
      S_ML: begin
        cmd.op     = OP_MUL_L;
        state_next = S_ML2;
      end
      S_ML2: begin
        cmd.op     = OP_MUL_L2;
        state_next = S_PROG;
      end
      S_PROG: begin
        cmd.op     = OP_PROG;
        state_next = S_MS;
      end
      S_MS: begin
        cmd.op     = OP_MUL_S;
        state_next = S_DIVW;
      end
      S_DIVW: begin
        if (status.div_done) begin
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        cmd.op     = OP_STEP;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.op     = OP_FINISH;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

/* rtl/sasg_dp.sv */
// ----------------------------------------------------------------------------
// sasg_dp
// Datapath: queues, profile and step arithmetic, limit checks, result beat.
// ----------------------------------------------------------------------------
module sasg_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  sasg_pkg::sasg_cmd_t    cmd,
  output sasg_pkg::sasg_status_t status,
  input  sasg_pkg::sasg_in_t     in_data,
  input  logic [7:0]             freq_multiplier,
  input  logic [16:0]            max_speed_q16,
  input  logic [17:0]            max_accel_q16,
  output logic                   out_valid,
  input  logic                   out_ready,
  output sasg_pkg::sasg_out_t    out_data
);
  import sasg_pkg::*;

  logic [MQ_AW-1:0] mq_head;
  logic [MQ_CW-1:0] mq_count;
  logic [TQ_AW-1:0] tq_head;
  logic [TQ_CW-1:0] tq_count;
  logic [31:0] seg_steps, seg_length, steps_done;
  logic        seg_positive;
  logic [31:0] progress_in_move, progress_in_timing, progress_total;
  logic [31:0] timing_ticks, timing_duration, rate_change, rate_initial;
  logic        rate_sign_neg, done_flag, last_sign_neg;
  logic [31:0] motor_pos, since_step, prev_interval, time_count;
  logic        stepped, sv, av, dropped;
  logic [31:0] base_a, q_term, l_term, df, ds;
  logic [ENTRY_W-1:0] mq_rdata, tq_rdata;
  logic        mq_we, tq_we, push_drop;
  logic [MQ_AW-1:0] mq_waddr;
  logic [TQ_AW-1:0] tq_waddr;
  logic [31:0] fsq, two_d;
  logic [31:0] t_base, t0, t1, sdiff0, sdiff1;
  logic [23:0] amt_mag;
  logic [16:0] rcp_now, rcp_prev;
  logic signed [18:0] acc_d;
  logic [18:0] acc_mag;
  logic [31:0] ab1, ab0;
  logic [31:0] dl_prod;
  logic [31:0] q_part, l_part, qt_prod;
  logic [31:0] step_gap;
  logic [4:0]  div_cnt;
  logic [16:0] div_n, div_dvd, div_rem, div_q;
  logic [17:0] div_trial, div_sub;
  logic        div_ge;

  // Tick-count end of timing segment, step-time terms.
  assign fsq   = {24'd0, freq_multiplier} * {24'd0, freq_multiplier};
  assign two_d = {timing_duration[30:0], 1'b0};
  assign status.timing_due = (timing_ticks == timing_duration * {24'd0, freq_multiplier});
  assign status.move_due   = (progress_in_move == seg_length);
  assign status.div_done   = (div_cnt == '0);

  assign mq_waddr = mq_head + mq_count[MQ_AW-1:0];
  assign tq_waddr = tq_head + tq_count[TQ_AW-1:0];
  assign mq_we = (cmd.op == OP_PUSH) && (in_data.command == CMD_MOVE) &&
                 (mq_count < MQ_CW'(MOVE_DEPTH));
  assign tq_we = (cmd.op == OP_PUSH) && (in_data.command == CMD_TIMING) &&
                 (tq_count < TQ_CW'(TIMING_DEPTH));
  assign push_drop = (cmd.op == OP_PUSH) &&
                     (((in_data.command == CMD_MOVE) && !mq_we) ||
                      ((in_data.command == CMD_TIMING) && !tq_we));

  sasg_ram #(.WIDTH(ENTRY_W), .DEPTH(MOVE_DEPTH)) u_mq (
    .clk(clk), .we(mq_we), .waddr(mq_waddr),
    .wdata({in_data.signed_amount, in_data.span}), .raddr(mq_head), .rdata(mq_rdata)
  );
  sasg_ram #(.WIDTH(ENTRY_W), .DEPTH(TIMING_DEPTH)) u_tq (
    .clk(clk), .we(tq_we), .waddr(tq_waddr),
    .wdata({in_data.signed_amount, in_data.span}), .raddr(tq_head), .rdata(tq_rdata)
  );

  function automatic logic [23:0] mag24(input logic [23:0] a);
    mag24 = a[23] ? (24'd0 - a) : a;
  endfunction

  // Reciprocal of the step interval, one quotient bit per cycle.
  assign step_gap  = since_step + 32'd1;
  assign div_trial = {div_rem, div_dvd[16]};
  assign div_ge    = (div_trial >= {1'b0, div_n});
  assign div_sub   = div_trial - {1'b0, div_n};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0; div_n <= '0; div_dvd <= '0; div_rem <= '0; div_q <= '0;
    end else if (cmd.op == OP_DIV_START) begin
      div_cnt <= 5'(RCP_ITER);
      div_n   <= (step_gap > 32'd65536) ? 17'h1FFFF : step_gap[16:0];
      div_dvd <= 17'h10000;
      div_rem <= '0;
      div_q   <= '0;
    end else if (div_cnt != '0) begin
      div_cnt <= div_cnt - 1'b1;
      div_dvd <= {div_dvd[15:0], 1'b0};
      div_rem <= div_ge ? div_sub[16:0] : div_trial[16:0];
      div_q   <= {div_q[15:0], div_ge};
    end
  end

  assign amt_mag = mag24(tq_rdata[47:24]);
  assign t_base  = rate_sign_neg ? (base_a + q_term) : (base_a - q_term);
  assign t0      = mag32(t_base - l_term);
  assign t1      = mag32(t_base + dl_prod - l_term);
  assign qt_prod = q_part * timing_ticks;
  assign sdiff1  = ab1;
  assign sdiff0  = ab0;
  assign rcp_now = div_q;
  assign acc_d = (last_sign_neg ? -$signed({2'b0, rcp_prev}) : $signed({2'b0, rcp_prev})) -
                 (seg_positive ? $signed({2'b0, rcp_now}) : -$signed({2'b0, rcp_now}));
  assign acc_mag = acc_d[18] ? 19'(-acc_d) : 19'(acc_d);

  always_ff @(posedge clk) begin
    if (rst) begin
      mq_head <= '0; mq_count <= '0; tq_head <= '0; tq_count <= '0;
      seg_steps <= '0; seg_length <= '0; steps_done <= '0; seg_positive <= 1'b0;
      progress_in_move <= '0; progress_in_timing <= '0; progress_total <= '0;
      timing_ticks <= '0; timing_duration <= '0; rate_change <= '0;
      rate_initial <= '0; rate_sign_neg <= 1'b0; done_flag <= 1'b0;
      last_sign_neg <= 1'b0; motor_pos <= '0; since_step <= '0;
      prev_interval <= '0; time_count <= '0; out_valid <= 1'b0;
      stepped <= 1'b0; sv <= 1'b0; av <= 1'b0; dropped <= 1'b0;
      rcp_prev <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.clear_flags) begin
        stepped <= 1'b0; sv <= 1'b0; av <= 1'b0;
        dropped <= push_drop;
      end
      case (cmd.op)
        OP_PUSH: begin
          if (mq_we) mq_count <= mq_count + 1'b1;
          if (tq_we) tq_count <= tq_count + 1'b1;
        end
        OP_POP_T: begin
          progress_in_timing <= '0;
          timing_ticks <= '0;
          rate_initial <= rate_initial + (rate_sign_neg ? (32'd0 - rate_change) : rate_change);
          if (tq_count == '0) begin
            rate_change <= '0;
            timing_duration <= 32'd1 << FRAC_BITS;
          end else begin
            rate_change <= {8'd0, amt_mag};
            rate_sign_neg <= tq_rdata[47];
            timing_duration <= {8'd0, tq_rdata[23:0]};
            tq_head <= tq_head + 1'b1;
            tq_count <= tq_count - 1'b1;
          end
        end
        OP_POP_M: begin
          steps_done <= '0;
          progress_in_move <= '0;
          if (mq_count == '0) begin
            seg_steps <= '0; seg_length <= 32'd1; done_flag <= 1'b1;
          end else begin
            seg_steps <= {8'd0, mag24(mq_rdata[47:24])};
            seg_positive <= !mq_rdata[47];
            seg_length <= {8'd0, mq_rdata[23:0]};
            mq_head <= mq_head + 1'b1;
            mq_count <= mq_count - 1'b1;
          end
        end
        OP_MUL_A: begin
          timing_ticks <= timing_ticks + 1'b1;
          base_a <= two_d * progress_in_timing;
          l_part <= two_d * rate_initial;
          df <= fsq;
        end
        OP_MUL_Q: begin
          base_a <= base_a * df;
          dl_prod <= two_d * df;
          q_part <= rate_change * timing_ticks;
        end
        OP_MUL_L: begin
          q_term <= qt_prod >> FRAC_BITS;
          l_part <= l_part * timing_ticks;
        end
        OP_MUL_L2: begin
          l_term <= (l_part >> FRAC_BITS) * {24'd0, freq_multiplier};
        end
        OP_PROG: begin
          since_step <= since_step + 1'b1;
          time_count <= time_count + 1'b1;
          if (t1 < t0) begin
            progress_in_timing <= progress_in_timing + 1'b1;
            progress_in_move <= progress_in_move + 1'b1;
            progress_total <= progress_total + 1'b1;
            ds <= seg_steps * (progress_in_move + 1'b1);
          end else begin
            ds <= seg_steps * progress_in_move;
          end
        end
        OP_MUL_S: begin
          ab0 <= mag32(steps_done * seg_length - ds);
          ab1 <= mag32(steps_done * seg_length + seg_length - ds);
        end
        OP_STEP: begin
          if (sdiff1 < sdiff0) begin
            stepped <= 1'b1;
            if (since_step != '0 && {15'd0, rcp_now} > {15'd0, max_speed_q16}) sv <= 1'b1;
            if (prev_interval != '0 && since_step != '0 &&
                acc_mag > {1'b0, max_accel_q16}) av <= 1'b1;
            prev_interval <= since_step;
            rcp_prev <= rcp_now;
            since_step <= '0;
            motor_pos <= motor_pos + (seg_positive ? 32'd1 : 32'hFFFF_FFFF);
            last_sign_neg <= !seg_positive;
            steps_done <= steps_done + 1'b1;
          end
        end
        OP_FINISH: begin
          out_valid <= 1'b1;
          out_data.stepped <= stepped;
          out_data.direction <= !last_sign_neg;
          out_data.motor_position <= motor_pos;
          out_data.progress <= progress_total;
          out_data.all_done <= done_flag;
          out_data.speed_violation <= sv;
          out_data.accel_violation <= av;
          out_data.tick_time <= time_count;
          out_data.push_dropped <= dropped;
        end
        default: ;
      endcase
    end
  end
endmodule

/* dv/stepper_axis_step_generator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_axis_step_generator_tb
// Drives push and tick beats with random gaps and stalls on both channels,
// predicts each result beat from a cycle-free model of the axis (queues,
// quadratic profile, step test, limit flags) and compares every field.
// ----------------------------------------------------------------------------
module stepper_axis_step_generator_tb;
  import sasg_pkg::*;

  localparam logic [1:0]         CMD_SPARE = 2'd3;
  localparam logic [PADDR_W-1:0] REG_NONE  = 4'hC;
  localparam int                 LIMIT     = 3000000;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sasg_in_if  in_ch ();
  sasg_out_if out_ch ();

  stepper_axis_step_generator dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // axis state
  bit [31:0] freq_mul, speed_lim, accel_lim;
  bit [23:0] mq_amt [MOVE_DEPTH];
  bit [23:0] mq_span [MOVE_DEPTH];
  bit [23:0] tq_amt [TIMING_DEPTH];
  bit [23:0] tq_span [TIMING_DEPTH];
  int        mq_head, mq_cnt, tq_head, tq_cnt;
  bit [31:0] seg_steps, seg_len, steps_done;
  bit        seg_pos;
  bit [31:0] prog_move, prog_timing, prog_total;
  bit [31:0] t_ticks, t_dur, r_chg, r_init;
  bit        r_neg, done_flag, last_neg;
  bit [31:0] motor_pos, since_step, prev_ivl, tick_count;

  sasg_out_t expected_beats[$];
  int        mismatches;
  int        src_idle_pct, snk_idle_pct;
  int        hold_cycles;
  longint    cycles;

  function automatic bit [31:0] abs32(bit [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  function automatic bit [31:0] abs24(bit [23:0] a, output bit neg);
    bit [23:0] m;
    neg = a[23];
    m = neg ? (24'd0 - a) : a;
    return {8'd0, m};
  endfunction

  function automatic longint recip(bit [31:0] n);
    return longint'(32'd65536 / n);
  endfunction

  function automatic bit [31:0] profile_dist(bit [31:0] k);
    bit [31:0] a, q, l, p;
    a = 32'd2 * t_dur * (prog_timing + k) * freq_mul * freq_mul;
    p = r_chg * t_ticks * t_ticks;
    q = p >> FRAC_BITS;
    p = 32'd2 * t_dur * r_init * t_ticks;
    l = (p >> FRAC_BITS) * freq_mul;
    a = r_neg ? a + q : a - q;
    return abs32(a - l);
  endfunction

  task automatic next_timing();
    prog_timing = 0;
    t_ticks = 0;
    r_init += r_neg ? (32'd0 - r_chg) : r_chg;
    if (tq_cnt == 0) begin
      r_chg = 0;
      t_dur = 32'd1 << FRAC_BITS;
    end else begin
      r_chg = abs24(tq_amt[tq_head], r_neg);
      t_dur = {8'd0, tq_span[tq_head]};
      tq_head = (tq_head + 1) % TIMING_DEPTH;
      tq_cnt--;
    end
  endtask

  task automatic next_move();
    bit neg;
    steps_done = 0;
    prog_move = 0;
    if (mq_cnt == 0) begin
      seg_steps = 0;
      seg_len = 1;
      done_flag = 1'b1;
    end else begin
      seg_steps = abs24(mq_amt[mq_head], neg);
      seg_pos = !neg;
      seg_len = {8'd0, mq_span[mq_head]};
      mq_head = (mq_head + 1) % MOVE_DEPTH;
      mq_cnt--;
    end
  endtask

  task automatic predict_axis(input sasg_in_t it, output sasg_out_t r);
    bit        stepped, sv, av, dropped;
    bit [31:0] d_next, d_now;
    longint    a, b, d;
    stepped = 0;
    sv = 0;
    av = 0;
    dropped = 0;
    case (it.command)
      CMD_MOVE: begin
        if (mq_cnt >= MOVE_DEPTH) begin
          dropped = 1;
        end else begin
          mq_amt[(mq_head + mq_cnt) % MOVE_DEPTH] = it.signed_amount;
          mq_span[(mq_head + mq_cnt) % MOVE_DEPTH] = it.span;
          mq_cnt++;
        end
      end
      CMD_TIMING: begin
        if (tq_cnt >= TIMING_DEPTH) begin
          dropped = 1;
        end else begin
          tq_amt[(tq_head + tq_cnt) % TIMING_DEPTH] = it.signed_amount;
          tq_span[(tq_head + tq_cnt) % TIMING_DEPTH] = it.span;
          tq_cnt++;
        end
      end
      CMD_TICK: begin
        if (t_ticks == t_dur * freq_mul) next_timing();
        t_ticks++;
        if (prog_move == seg_len) next_move();
        if (profile_dist(1) < profile_dist(0)) begin
          prog_timing++;
          prog_move++;
          prog_total++;
        end
        since_step++;
        tick_count++;
        d_next = (steps_done + 32'd1) * seg_len - seg_steps * prog_move;
        d_now = steps_done * seg_len - seg_steps * prog_move;
        if (abs32(d_next) < abs32(d_now)) begin
          if (since_step != 0 && recip(since_step) > longint'(speed_lim)) sv = 1;
          if (prev_ivl != 0 && since_step != 0) begin
            a = recip(prev_ivl);
            b = recip(since_step);
            d = (last_neg ? -a : a) - (seg_pos ? b : -b);
            if (d < 0) d = -d;
            if (d > longint'(accel_lim)) av = 1;
          end
          prev_ivl = since_step;
          since_step = 0;
          motor_pos += seg_pos ? 32'd1 : 32'hFFFF_FFFF;
          last_neg = !seg_pos;
          steps_done++;
          stepped = 1;
        end
      end
      default: ;
    endcase
    r.stepped         = stepped;
    r.direction       = !last_neg;
    r.motor_position  = motor_pos;
    r.progress        = prog_total;
    r.all_done        = done_flag;
    r.speed_violation = sv;
    r.accel_violation = av;
    r.tick_time       = tick_count;
    r.push_dropped    = dropped;
  endtask

  task automatic send_item(input logic [1:0] cmd, input logic [23:0] amt,
                           input logic [23:0] spn);
    sasg_in_t  it;
    sasg_out_t r;
    it.command = cmd;
    it.signed_amount = amt;
    it.span = spn;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    forever begin
      @(negedge clk);
      if (in_ch.ready) break;
    end
    @(posedge clk);
    predict_axis(it, r);
    expected_beats.insert(expected_beats.size(), r);
  endtask

  task automatic ticks(input int n);
    repeat (n) send_item(CMD_TICK, 24'($urandom), 24'($urandom));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [31:0] val);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (addr)
      REG_FREQ:  freq_mul = val & 32'hFF;
      REG_SPEED: speed_lim = val & 32'h1FFFF;
      REG_ACCEL: accel_lim = val & 32'h3FFFF;
      default: ;
    endcase
  endtask

  task automatic write_limits(input logic [31:0] f, input logic [31:0] s,
                              input logic [31:0] a);
    write_reg(REG_FREQ, f);
    write_reg(REG_SPEED, s);
    write_reg(REG_ACCEL, a);
  endtask

  task automatic test_queue_limits();
    for (int i = 0; i < MOVE_DEPTH + 1; i++) send_item(CMD_MOVE, 24'd1, 24'd0);
    for (int i = 0; i < TIMING_DEPTH + 1; i++) send_item(CMD_TIMING, 24'd65536, 24'd1);
    send_item(CMD_SPARE, 24'hFFFFFF, 24'hFFFFFF);
    ticks(40);
  endtask

  task automatic test_field_extremes();
    send_item(CMD_TIMING, 24'h7FFFFF, 24'd4);
    send_item(CMD_TIMING, 24'h800000, 24'd4);
    send_item(CMD_TIMING, 24'h000000, 24'd2);
    send_item(CMD_MOVE, 24'h800000, 24'd3);
    send_item(CMD_MOVE, 24'h7FFFFF, 24'd2);
    send_item(CMD_MOVE, 24'hFFFFFD, 24'd6);
    send_item(CMD_MOVE, 24'd0, 24'd1);
    ticks(30);
  endtask

  task automatic test_random(input int n);
    int sent;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 8) begin
        send_item(2'($urandom_range(3)), 24'($urandom), 24'($urandom_range(255)));
        sent++;
      end else begin
        repeat ($urandom_range(2)) begin
          send_item(CMD_TIMING, 24'($urandom), 24'($urandom_range(1, 48)));
          sent++;
        end
        repeat ($urandom_range(2)) begin
          if ($urandom_range(9) == 0)
            send_item(CMD_MOVE, 24'($urandom), 24'($urandom_range(0, 120)));
          else
            send_item(CMD_MOVE, $urandom_range(1) ? 24'(-$urandom_range(40))
                                                  : 24'($urandom_range(40)),
                      24'($urandom_range(0, 120)));
          sent++;
        end
        repeat ($urandom_range(5, 40)) begin
          send_item(CMD_TICK, 24'($urandom), 24'($urandom));
          sent++;
        end
      end
    end
    drain();
  endtask

  task automatic test_backpressure();
    int saved;
    saved = src_idle_pct;
    src_idle_pct = 0;
    hold_cycles = 300;
    ticks(25);
    src_idle_pct = saved;
    drain();
  endtask

  task automatic test_long_segments();
    write_limits(32'd255, 32'd65536, 32'd131072);
    send_item(CMD_TIMING, 24'h7FFFFF, 24'hFFFFFF);
    send_item(CMD_TIMING, 24'd100, 24'd0);
    send_item(CMD_MOVE, 24'd5, 24'hFFFFFF);
    ticks(60);
    drain();
  endtask

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    freq_mul = 1;
    speed_lim = 65536;
    accel_lim = 131072;
    mismatches = 0;
    hold_cycles = 0;
    src_idle_pct = 37;
    snk_idle_pct = 53;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_queue_limits();
    test_field_extremes();
    write_limits(32'd3, 32'd0, 32'd0);
    write_reg(REG_NONE, 32'hFFFF_FFFF);
    test_random(500);
    src_idle_pct = 53;
    snk_idle_pct = 37;
    write_limits(32'd1, $urandom_range(65536), $urandom_range(131072));
    test_random(500);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_limits(32'd2, 32'd65536, 32'd131072);
    test_random(300);
    test_backpressure();
    test_long_segments();
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(negedge clk) begin
    sasg_out_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", out_ch.data);
      end else begin
        want = expected_beats.pop_front();
        if (out_ch.data !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %p got %p", want, out_ch.data);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial cycles = 0;

endmodule
